// ===== design/tova_pkg.sv =====
// ---------------------------------------------------------------------------
// tova_pkg
// Shared types and constants of the timestamp-ordered vote arbiter.
// ---------------------------------------------------------------------------
package tova_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int STAMP_W         = 32;

   typedef enum logic [1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_CHECK   = 2'd1,
      CMD_GIVEUP  = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_NOT_GRANTED = 2'd0,
      ST_DONE        = 2'd1,
      ST_ERROR       = 2'd2,
      ST_FULL        = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

endpackage

// ===== design/tova_req_if.sv =====
// ---------------------------------------------------------------------------
// tova_req_if
// Request channel: command and request stamp with valid/ready.
// ---------------------------------------------------------------------------
interface tova_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [tova_pkg::STAMP_W-1:0]  request_stamp;

   modport source (output valid, output cmd, output request_stamp, input ready);
   modport sink   (input valid, input cmd, input request_stamp, output ready);
endinterface

// ===== design/tova_rsp_if.sv =====
// ---------------------------------------------------------------------------
// tova_rsp_if
// Response channel: status with valid/ready.
// ---------------------------------------------------------------------------
interface tova_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

// ===== design/timestamp_ordered_vote_arbiter.sv =====
// ---------------------------------------------------------------------------
// timestamp_ordered_vote_arbiter
// Quorum voter: pending stamp table in RAM, one vote granted to the
// smallest pending stamp.
// ---------------------------------------------------------------------------
// One item at a time. An accepted item moves through the scan, drain and
// finish states: in the scan state the stamp RAM is swept one entry per cycle
// through its single read port to find the stamp, the smallest pending stamp
// and the lowest free slot, then the drain state takes the last read data and
// the finish state updates the table and vote and loads the result register.
// The next item is accepted in the cycle after that, while the result may still
// wait to be taken. The finish state holds while an earlier result has not been
// taken, which stretches the item by that stall. Valid bits live in flip-flops
// and are cleared by reset.
module timestamp_ordered_vote_arbiter #(
   parameter int TABLE_DEPTH = tova_pkg::TABLE_DEPTH_DEF,
   localparam int AW         = $clog2(TABLE_DEPTH)
) (
   input  logic       clock,
   input  logic       reset,
   tova_req_if.sink   req_chan,
   tova_rsp_if.source rsp_chan
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   tova_pkg::state_type            state_ff, state_in;
   tova_pkg::cmd_type              cmd_ff, cmd_in;
   logic [tova_pkg::STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [AW-1:0]                  scan_addr_ff, scan_addr_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic [AW-1:0]                  rd_idx_ff, rd_idx_in;
   logic                           found_ff, found_in;
   logic [AW-1:0]                  found_idx_ff, found_idx_in;
   logic                           any_ff, any_in;
   logic [tova_pkg::STAMP_W-1:0]   least_ff, least_in;
   logic                           free_found_ff, free_found_in;
   logic [AW-1:0]                  free_idx_ff, free_idx_in;
   logic [TABLE_DEPTH-1:0]         valid_ff, valid_in;
   logic                           vote_given_ff, vote_given_in;
   logic [tova_pkg::STAMP_W-1:0]   vote_holder_ff, vote_holder_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   tova_pkg::status_type           status_ff, status_in;

   logic                           req_take;
   logic                           fin_go;
   logic                           entry_valid;
   logic [tova_pkg::STAMP_W-1:0]   rd_data;
   logic                           ram_we;
   logic [tova_pkg::STAMP_W-1:0]   least_new;
   logic                           held;

   tova_ram #(
      .WIDTH (tova_pkg::STAMP_W),
      .DEPTH (TABLE_DEPTH)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_idx_ff),
      .wr_data (stamp_ff),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == tova_pkg::S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign fin_go         = (state_ff == tova_pkg::S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign entry_valid    = valid_ff[rd_idx_ff];
   assign least_new      = (any_ff && (least_ff < stamp_ff)) ? least_ff : stamp_ff;
   assign held           = vote_given_ff && (vote_holder_ff == stamp_ff);

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      stamp_in       = stamp_ff;
      scan_addr_in   = scan_addr_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = scan_addr_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      any_in         = any_ff;
      least_in       = least_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      valid_in       = valid_ff;
      vote_given_in  = vote_given_ff;
      vote_holder_in = vote_holder_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      status_in      = status_ff;
      ram_we         = 1'b0;

      // fold in one read entry
      if (rd_vld_ff) begin
         if (entry_valid) begin
            if (rd_data == stamp_ff) begin
               found_in     = 1'b1;
               found_idx_in = rd_idx_ff;
            end
            if (!any_ff || (rd_data < least_ff)) begin
               any_in   = 1'b1;
               least_in = rd_data;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      unique case (state_ff)
         tova_pkg::S_IDLE: begin
            if (req_take) begin
               cmd_in        = tova_pkg::cmd_type'(req_chan.cmd);
               stamp_in      = req_chan.request_stamp;
               scan_addr_in  = '0;
               found_in      = 1'b0;
               any_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = tova_pkg::S_SCAN;
            end
         end
         tova_pkg::S_SCAN: begin
            rd_vld_in = 1'b1;
            if (scan_addr_ff == LAST_ADDR) begin
               state_in = tova_pkg::S_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         tova_pkg::S_DRAIN: begin
            state_in = tova_pkg::S_FINISH;
         end
         tova_pkg::S_FINISH: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               state_in     = tova_pkg::S_IDLE;
               case (cmd_ff) inside
                  tova_pkg::CMD_ACQUIRE: begin
                     if (!found_ff && !free_found_ff) begin
                        status_in = tova_pkg::ST_FULL;
                     end else begin
                        if (!found_ff) begin
                           ram_we                = 1'b1;
                           valid_in[free_idx_ff] = 1'b1;
                        end
                        if (!vote_given_ff && (least_new == stamp_ff)) begin
                           vote_given_in  = 1'b1;
                           vote_holder_in = stamp_ff;
                           status_in      = tova_pkg::ST_DONE;
                        end else begin
                           status_in = tova_pkg::ST_NOT_GRANTED;
                        end
                     end
                  end
                  tova_pkg::CMD_CHECK: begin
                     if (!any_ff) begin
                        status_in = tova_pkg::ST_ERROR;
                     end else if (!vote_given_ff && (least_ff == stamp_ff)) begin
                        vote_given_in  = 1'b1;
                        vote_holder_in = stamp_ff;
                        status_in      = tova_pkg::ST_DONE;
                     end else begin
                        status_in = tova_pkg::ST_NOT_GRANTED;
                     end
                  end
                  tova_pkg::CMD_GIVEUP, tova_pkg::CMD_RELEASE: begin
                     if (!any_ff) begin
                        status_in = tova_pkg::ST_ERROR;
                     end else begin
                        if (held) begin
                           vote_given_in = 1'b0;
                        end
                        if (found_ff) begin
                           valid_in[found_idx_ff] = 1'b0;
                        end
                        status_in = ((cmd_ff == tova_pkg::CMD_GIVEUP) || held) ?
                                    tova_pkg::ST_DONE : tova_pkg::ST_ERROR;
                     end
                  end
                  default: begin
                     status_in = tova_pkg::ST_ERROR;
                  end
               endcase
            end
         end
         default: begin
            state_in = tova_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tova_pkg::S_IDLE;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         vote_given_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         vote_given_ff <= vote_given_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      stamp_ff       <= stamp_in;
      scan_addr_ff   <= scan_addr_in;
      rd_idx_ff      <= rd_idx_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      any_ff         <= any_in;
      least_ff       <= least_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      vote_holder_ff <= vote_holder_in;
      status_ff      <= status_in;
   end

endmodule

// ===== design/tova_ram.sv =====
// ---------------------------------------------------------------------------
// tova_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tova_ram #(
   parameter int WIDTH = tova_pkg::STAMP_W,
   parameter int DEPTH = tova_pkg::TABLE_DEPTH_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tova_checker.sv =====
// ---------------------------------------------------------------------------
// tova_checker
// Port-level checks of the vote arbiter, bound to the top level.
// ---------------------------------------------------------------------------
module tova_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

   // drop ready after an accept (checked only at the start of the table sweep)
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("item accepted during sweep");

   // leave reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // no result rises at the start of an item's sweep
   a_no_rsp_mid_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result appeared mid sweep");

endmodule

bind timestamp_ordered_vote_arbiter tova_checker u_tova_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status)
);

// ===== bench/timestamp_ordered_vote_arbiter_tb.sv =====
// ---------------------------------------------------------------------------
// timestamp_ordered_vote_arbiter_tb
// Self-checking bench for the quorum voter. A scoreboard class keeps its own
// copy of the pending stamp table and the vote, predicts the status of every
// accepted request and checks each response in order. Directed requests cover
// the empty table, duplicate stamps, non-holder release and a full table;
// random requests over a small stamp pool then run under three idle profiles,
// with one long response stall that backs the block up.
// ---------------------------------------------------------------------------
module timestamp_ordered_vote_arbiter_tb;

   localparam int DEPTH       = tova_pkg::TABLE_DEPTH_DEF;
   localparam int SW          = tova_pkg::STAMP_W;
   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 24;

   class vote_scoreboard;
      bit [SW-1:0]          stamps [DEPTH];
      bit                   occupied [DEPTH];
      bit                   vote_given;
      bit [SW-1:0]          holder;
      tova_pkg::status_type expected_status [$];
      int                   errors;

      function new();
         for (int i = 0; i < DEPTH; i++) begin
            stamps[i]   = '0;
            occupied[i] = 1'b0;
         end
         vote_given = 1'b0;
         holder     = '0;
         errors     = 0;
      endfunction

      function int slot_of(bit [SW-1:0] s);
         for (int i = 0; i < DEPTH; i++)
            if (occupied[i] && stamps[i] == s) return i;
         return -1;
      endfunction

      function bit table_empty();
         for (int i = 0; i < DEPTH; i++)
            if (occupied[i]) return 1'b0;
         return 1'b1;
      endfunction

      function bit least_pending(output bit [SW-1:0] least);
         bit any;
         any   = 1'b0;
         least = '0;
         for (int i = 0; i < DEPTH; i++)
            if (occupied[i] && (!any || stamps[i] < least)) begin
               least = stamps[i];
               any   = 1'b1;
            end
         return any;
      endfunction

      function tova_pkg::status_type grant_vote(bit [SW-1:0] s);
         bit [SW-1:0] least;
         if (least_pending(least) && !vote_given && least == s) begin
            vote_given = 1'b1;
            holder     = s;
            return tova_pkg::ST_DONE;
         end
         return tova_pkg::ST_NOT_GRANTED;
      endfunction

      function void note_request(tova_pkg::cmd_type c, bit [SW-1:0] s);
         tova_pkg::status_type st;
         int                   slot;
         int                   free_slot;
         bit                   held;
         st = tova_pkg::ST_NOT_GRANTED;
         if (c == tova_pkg::CMD_ACQUIRE) begin
            free_slot = -1;
            if (slot_of(s) < 0) begin
               for (int i = DEPTH - 1; i >= 0; i--)
                  if (!occupied[i]) free_slot = i;
               if (free_slot >= 0) begin
                  stamps[free_slot]   = s;
                  occupied[free_slot] = 1'b1;
                  st = grant_vote(s);
               end else begin
                  st = tova_pkg::ST_FULL;
               end
            end else begin
               st = grant_vote(s);
            end
         end else if (table_empty()) begin
            st = tova_pkg::ST_ERROR;
         end else if (c == tova_pkg::CMD_CHECK) begin
            st = grant_vote(s);
         end else begin
            held = vote_given && holder == s;
            if (held) vote_given = 1'b0;
            slot = slot_of(s);
            if (slot >= 0) occupied[slot] = 1'b0;
            st = (c == tova_pkg::CMD_GIVEUP || held) ? tova_pkg::ST_DONE
                                                     : tova_pkg::ST_ERROR;
         end
         expected_status.push_back(st);
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_status(logic [1:0] got);
         tova_pkg::status_type want;
         if (expected_status.size() == 0) begin
            report_mismatch($sformatf("unexpected response, status %0d", got));
         end else begin
            want = expected_status.pop_front();
            if (got !== want)
               report_mismatch($sformatf("status %0d, predicted %0d", got, want));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   stall_request;
   bit [SW-1:0]    stamp_pool [POOL_SIZE];
   vote_scoreboard sb;

   tova_req_if req_bus ();
   tova_rsp_if rsp_bus ();

   timestamp_ordered_vote_arbiter #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = tova_pkg::CMD_ACQUIRE;
      req_bus.request_stamp = '0;
      rsp_bus.ready         = 1'b0;
      send_idle_pct         = 0;
      recv_idle_pct         = 0;
      stall_request         = 1'b0;
      cycles                = 0;
      sb                    = new();
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_request(tova_pkg::cmd_type'(req_bus.cmd), req_bus.request_stamp);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_status(rsp_bus.status);
   end

   initial begin
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            for (int i = 0; i < 300; i++) begin
               rsp_bus.ready <= 1'b0;
               @(negedge clock);
            end
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_item(tova_pkg::cmd_type c, bit [SW-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= c;
      req_bus.request_stamp <= s;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic refill_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         if ($urandom_range(3) == 0)
            stamp_pool[i] = $urandom;
         else
            stamp_pool[i] = {16'($urandom_range(63)), 16'($urandom_range(15))};
      end
   endtask

   task automatic send_random_item();
      tova_pkg::cmd_type c;
      bit [SW-1:0]       s;
      bit [SW-1:0]       least;
      int                r;
      r = $urandom_range(99);
      if (r < 40)      c = tova_pkg::CMD_ACQUIRE;
      else if (r < 60) c = tova_pkg::CMD_CHECK;
      else if (r < 75) c = tova_pkg::CMD_GIVEUP;
      else             c = tova_pkg::CMD_RELEASE;
      r = $urandom_range(99);
      s = stamp_pool[$urandom_range(POOL_SIZE - 1)];
      if (r < 10) begin
         s = $urandom;
      end else if (r < 35 && sb.vote_given && c == tova_pkg::CMD_RELEASE) begin
         s = sb.holder;
      end else if (r < 35 && c == tova_pkg::CMD_CHECK) begin
         if (sb.least_pending(least)) s = least;
      end
      send_item(c, s);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(tova_pkg::CMD_CHECK,   32'h0000_0000);
      send_item(tova_pkg::CMD_GIVEUP,  32'h0000_0000);
      send_item(tova_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
      send_item(tova_pkg::CMD_ACQUIRE, 32'h0000_0000);
      send_item(tova_pkg::CMD_ACQUIRE, 32'h0000_0000);
      send_item(tova_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
      send_item(tova_pkg::CMD_ACQUIRE, 32'hFFFF_FFFF);
      send_item(tova_pkg::CMD_CHECK,   32'hFFFF_FFFF);
      send_item(tova_pkg::CMD_GIVEUP,  32'h0000_0000);
      send_item(tova_pkg::CMD_CHECK,   32'hFFFF_FFFF);
      send_item(tova_pkg::CMD_RELEASE, 32'hFFFF_FFFF);
      for (int i = 0; i < DEPTH; i++)
         send_item(tova_pkg::CMD_ACQUIRE, {4'(DEPTH - 1 - i), 28'h5A5_A5A5 ^ 28'(i)});
      send_item(tova_pkg::CMD_ACQUIRE, 32'h8000_0001);
      send_item(tova_pkg::CMD_ACQUIRE, {4'(DEPTH - 1), 28'h5A5_A5A5});
      send_item(tova_pkg::CMD_CHECK,   {4'(0), 28'h5A5_A5A5 ^ 28'(DEPTH - 1)});

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 37 : 0;
         refill_pool();
         if (phase == 1) stall_request = 1'b1;
         repeat (300) send_random_item();
      end
      req_bus.valid <= 1'b0;

      while (sb.expected_status.size() != 0) @(posedge clock);
      repeat (2 * (DEPTH + 3)) @(posedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
